FILE: rtl/text_mode_terminal_writer_unit_defines.svh
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_unit_defines
// Assertion macros used by ttw_ctrl; each expects clock and reset
// in scope
// ---------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication
`define TTW_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ttw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttw_pkg
// Types, constants and helpers of the text-mode terminal writer
// ---------------------------------------------------------------------------
package ttw_pkg;

   // screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int NUM_CELLS = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(NUM_CELLS);
   localparam int CNT_W     = $clog2(NUM_CELLS + 1);
   localparam int CELL_W    = 16;

   // field widths
   localparam int ROW_W = 5;
   localparam int COL_W = 7;

   // command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // character codes and colors
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] RESET_COLOR  = 8'd7;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [CELL_W-1:0] cell_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      row_type    read_row;
      col_type    read_col;
   } req_type;

   typedef struct packed {
      row_type    cursor_row;
      col_type    cursor_col;
      logic [7:0] cell_char;
      logic [7:0] cell_color;
      logic       did_scroll;
   } rsp_type;

   // controller to output stage
   typedef struct packed {
      logic    load;
      rsp_type data;
   } result_type;

   // linear cell address of a row and column
   function automatic addr_type cell_addr(row_type r, col_type c);
      return addr_type'(int'(r) * COLUMNS + int'(c));
   endfunction

endpackage

FILE: rtl/ttw_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttw_ram
// Generic simple dual-port RAM: one write port, one registered read port
// ---------------------------------------------------------------------------
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ttw_ctrl.sv
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_unit_defines.svh"
// ---------------------------------------------------------------------------
// ttw_ctrl
// Command sequencer: cursor, cell writes, reads, clear fill and scroll copy
// ---------------------------------------------------------------------------
module ttw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ttw_pkg::req_type    req_data,
   input  logic [7:0]          text_color,
   input  logic                rsp_room,
   output ttw_pkg::result_type result,
   output logic                wr_en,
   output ttw_pkg::addr_type   wr_addr,
   output ttw_pkg::cell_type   wr_data,
   output logic                rd_en,
   output ttw_pkg::addr_type   rd_addr,
   input  ttw_pkg::cell_type   rd_data
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   ttw_pkg::req_type   req_ff, req_in;
   ttw_pkg::row_type   row_ff, row_in;
   ttw_pkg::col_type   col_ff, col_in;
   ttw_pkg::cell_type  cell_ff, cell_in;
   logic               scroll_ff, scroll_in;
   ttw_pkg::cnt_type   idx_ff, idx_in;
   ttw_pkg::cnt_type   dst_ff, dst_in;
   logic               pend_ff, pend_in;
   logic [7:0]         fill_color_ff, fill_color_in;
   ttw_pkg::row_type   bs_row;
   ttw_pkg::col_type   bs_col;
   logic               last_row;
   logic               last_col;
   logic               result_load;

   assign last_row = (row_ff == ttw_pkg::row_type'(ttw_pkg::ROWS - 1));
   assign last_col = (col_ff == ttw_pkg::col_type'(ttw_pkg::COLUMNS - 1));

   // cursor after a backspace
   always_comb begin
      bs_row = row_ff;
      bs_col = col_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         bs_row = row_ff - 1'b1;
         bs_col = ttw_pkg::col_type'(ttw_pkg::COLUMNS - 1);
      end
   end

   // next state and memory control
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cell_in       = cell_ff;
      scroll_in     = scroll_ff;
      idx_in        = idx_ff;
      dst_in        = dst_ff;
      pend_in       = pend_ff;
      fill_color_in = fill_color_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      result_load   = 1'b0;

      case (state_ff)
         // blank fill after reset or on clear
         ST_INIT, ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ttw_pkg::ADDR_W-1:0];
            wr_data = {fill_color_ff, ttw_pkg::CH_SPACE};
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == ttw_pkg::cnt_type'(ttw_pkg::NUM_CELLS - 1)) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end

         // take a request beat
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end

         // decode and carry out the command
         ST_EXEC: begin
            cell_in   = '0;
            scroll_in = 1'b0;
            state_in  = ST_DONE;
            case (req_ff.cmd)
               ttw_pkg::CMD_PUT: begin
                  if (req_ff.char_code == ttw_pkg::CH_NEWLINE) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else if (req_ff.char_code == ttw_pkg::CH_BACKSPACE) begin
                     row_in  = bs_row;
                     col_in  = bs_col;
                     wr_en   = 1'b1;
                     wr_addr = ttw_pkg::cell_addr(bs_row, bs_col);
                     wr_data = {text_color, ttw_pkg::CH_SPACE};
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = ttw_pkg::cell_addr(row_ff, col_ff);
                     wr_data = {text_color, req_ff.char_code};
                     if (last_col) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  // moving past the last row starts a scroll
                  if (req_ff.char_code != ttw_pkg::CH_BACKSPACE && last_row &&
                      (req_ff.char_code == ttw_pkg::CH_NEWLINE || last_col)) begin
                     row_in    = ttw_pkg::row_type'(ttw_pkg::ROWS - 1);
                     col_in    = '0;
                     scroll_in = 1'b1;
                     idx_in    = ttw_pkg::cnt_type'(ttw_pkg::COLUMNS);
                     dst_in    = '0;
                     pend_in   = 1'b0;
                     state_in  = ST_SCROLL_COPY;
                  end
               end
               ttw_pkg::CMD_READ: begin
                  if (32'(req_ff.read_row) < ttw_pkg::ROWS &&
                      32'(req_ff.read_col) < ttw_pkg::COLUMNS) begin
                     rd_en    = 1'b1;
                     rd_addr  = ttw_pkg::cell_addr(req_ff.read_row, req_ff.read_col);
                     state_in = ST_READ_WAIT;
                  end
               end
               ttw_pkg::CMD_CLEAR: begin
                  row_in        = '0;
                  col_in        = '0;
                  idx_in        = '0;
                  fill_color_in = text_color;
                  state_in      = ST_CLEAR;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // read data arrives in the cycle after the address
         ST_READ_WAIT: begin
            cell_in  = rd_data;
            state_in = ST_DONE;
         end

         // move every row up: read one row below, write back in the next cycle
         ST_SCROLL_COPY: begin
            rd_en   = (idx_ff != ttw_pkg::cnt_type'(ttw_pkg::NUM_CELLS));
            rd_addr = idx_ff[ttw_pkg::ADDR_W-1:0];
            pend_in = rd_en;
            if (rd_en) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff[ttw_pkg::ADDR_W-1:0];
               wr_data = rd_data;
               dst_in  = dst_ff + 1'b1;
            end
            if (!rd_en) begin
               state_in = ST_SCROLL_BLANK;
            end
         end

         // blank the new bottom row
         ST_SCROLL_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[ttw_pkg::ADDR_W-1:0];
            wr_data = {text_color, ttw_pkg::CH_SPACE};
            dst_in  = dst_ff + 1'b1;
            if (dst_ff == ttw_pkg::cnt_type'(ttw_pkg::NUM_CELLS - 1)) begin
               state_in = ST_DONE;
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            result_load = rsp_room;
            if (rsp_room) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // result fields
   assign result.load            = result_load;
   assign result.data.cursor_row = row_ff;
   assign result.data.cursor_col = col_ff;
   assign result.data.cell_char  = cell_ff[7:0];
   assign result.data.cell_color = cell_ff[15:8];
   assign result.data.did_scroll = scroll_ff;

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         idx_ff        <= '0;
         dst_ff        <= '0;
         pend_ff       <= 1'b0;
         scroll_ff     <= 1'b0;
         fill_color_ff <= ttw_pkg::RESET_COLOR;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         idx_ff        <= idx_in;
         dst_ff        <= dst_in;
         pend_ff       <= pend_in;
         scroll_ff     <= scroll_in;
         fill_color_ff <= fill_color_in;
      end
      req_ff  <= req_in;
      cell_ff <= cell_in;
   end

   // checks
   `TTW_ASSERT_IMPL(a_cursor_range, 1'b1,
      (32'(row_ff) < ttw_pkg::ROWS) && (32'(col_ff) < ttw_pkg::COLUMNS),
      "cursor left the screen")
   `TTW_ASSERT_IMPL(a_scroll_home, result.load && result.data.did_scroll,
      (32'(row_ff) == ttw_pkg::ROWS - 1) && (col_ff == '0),
      "scroll result with cursor off the last row start")
   `TTW_ASSERT_NEXT(a_read_wait, (state_ff == ST_EXEC) && rd_en,
      state_ff == ST_READ_WAIT, "cell read not followed by data capture")
   `TTW_ASSERT_IMPL(a_copy_alias, wr_en && rd_en, wr_addr != rd_addr,
      "scroll copy reads the cell it writes")

endmodule

FILE: rtl/text_mode_terminal_writer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_unit
// Character-cell text console: cell buffer in RAM, cursor, scroll and clear
// ---------------------------------------------------------------------------
//  channel  direction  handshake          beat
//  req      in         req_valid/stall    cmd, char_code, read_row, read_col
//  rsp      out        rsp_valid/stall    cursor, cell bytes, did_scroll
//  csr      in         csr_valid/ready    text_color byte
//
//  every command passes through decode and a done state that hands its
//  result over; an on-screen read adds a state that takes the RAM data.
//  a scroll copies the rows up through the one RAM read port, then
//  blanks the bottom row; clear fills every cell with a blank.
//  after reset a blanking pass over all NUM_CELLS cells runs with
//  req_stall high; csr writes are taken at all times.
//  a stalled rsp beat holds in the output register; the next command is
//  worked on meanwhile and waits only to hand over its result.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ttw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   logic [7:0]          text_color_ff, text_color_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ttw_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                rsp_room;
   ttw_pkg::result_type result;
   logic                wr_en;
   ttw_pkg::addr_type   wr_addr;
   ttw_pkg::cell_type   wr_data;
   logic                rd_en;
   ttw_pkg::addr_type   rd_addr;
   ttw_pkg::cell_type   rd_data;

   // color register
   assign csr_ready     = 1'b1;
   assign text_color_in = (csr_valid && csr_ready) ? csr_data : text_color_ff;

   // output register
   assign rsp_room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= ttw_pkg::RESET_COLOR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         text_color_ff <= text_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // command sequencer
   ttw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .text_color (text_color_ff),
      .rsp_room   (rsp_room),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // cell buffer
   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (ttw_pkg::NUM_CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: dv/text_mode_terminal_writer_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_unit_checker
// Watches the req, rsp and csr channels of the text console. It keeps its
// own screen image, cursor and text color, works out the response of every
// accepted req beat and compares each accepted rsp beat field by field with
// the oldest response still owed.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_unit_checker
   import ttw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         pending
);

   // shadow console state
   cell_type   screen [NUM_CELLS];
   int         crow;
   int         ccol;
   logic [7:0] text_color;

   // responses owed by the block, oldest first
   rsp_type    owed_rsp [$];

   function automatic cell_type blank_cell();
      return {text_color, CH_SPACE};
   endfunction

   // step to the next line; scroll up one row when past the bottom
   function automatic bit next_line();
      int i;
      ccol = 0;
      crow++;
      if (crow < ROWS) begin
         return 1'b0;
      end
      for (i = 0; i + COLUMNS < NUM_CELLS; i++) begin
         screen[i] = screen[i + COLUMNS];
      end
      for (i = (ROWS - 1) * COLUMNS; i < NUM_CELLS; i++) begin
         screen[i] = blank_cell();
      end
      crow = ROWS - 1;
      return 1'b1;
   endfunction

   // apply one command to the shadow state and build its response
   function automatic rsp_type console_response(req_type cmd_beat);
      rsp_type  resp;
      cell_type read_cell;
      int       i;
      resp = '0;
      case (cmd_beat.cmd)
         CMD_PUT: begin
            if (cmd_beat.char_code == CH_NEWLINE) begin
               resp.did_scroll = next_line();
            end else if (cmd_beat.char_code == CH_BACKSPACE) begin
               // back one cell, across a line start, stuck at home
               if (ccol > 0) begin
                  ccol--;
               end else if (crow > 0) begin
                  crow--;
                  ccol = COLUMNS - 1;
               end
               screen[crow * COLUMNS + ccol] = blank_cell();
            end else begin
               screen[crow * COLUMNS + ccol] = {text_color, cmd_beat.char_code};
               ccol++;
               if (ccol >= COLUMNS) begin
                  resp.did_scroll = next_line();
               end
            end
         end
         CMD_READ: begin
            // cells off the screen read as zero
            if (cmd_beat.read_row < ROWS && cmd_beat.read_col < COLUMNS) begin
               read_cell = screen[int'(cmd_beat.read_row) * COLUMNS +
                                  int'(cmd_beat.read_col)];
               resp.cell_char  = read_cell[7:0];
               resp.cell_color = read_cell[15:8];
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < NUM_CELLS; i++) begin
               screen[i] = blank_cell();
            end
            crow = 0;
            ccol = 0;
         end
         default: begin
            // unused command leaves everything as it is
         end
      endcase
      resp.cursor_row = row_type'(crow);
      resp.cursor_col = col_type'(ccol);
      return resp;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < NUM_CELLS; i++) begin
            screen[i] = {RESET_COLOR, CH_SPACE};
         end
         crow       = 0;
         ccol       = 0;
         text_color = RESET_COLOR;
         fail_count = 0;
         owed_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            text_color = csr_data;
         end
         if (req_valid && !req_stall) begin
            owed_rsp.push_back(console_response(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp.size() == 0) begin
               $error("rsp beat with no response owed");
               fail_count++;
            end else begin
               want = owed_rsp.pop_front();
               check_field("cursor_row", want.cursor_row, rsp_data.cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_data.cursor_col);
               check_field("cell_char", want.cell_char, rsp_data.cell_char);
               check_field("cell_color", want.cell_color, rsp_data.cell_color);
               check_field("did_scroll", want.did_scroll, rsp_data.did_scroll);
            end
         end
      end
      pending = owed_rsp.size();
   end

endmodule

FILE: dv/tb_text_mode_terminal_writer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_mode_terminal_writer_unit
// Drives the text console with a short directed list (home reads, cells off
// the screen, backspace at home and at line start, line wrap, clear, the
// unused command) and then with phases of random text runs, read runs and
// noise under several text colors. Both channels idle at random and the
// rsp side holds off once for a long stretch. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_text_mode_terminal_writer_unit;
   import ttw_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int ITEMS       = 1300;
   localparam int PHASES      = 6;
   localparam int HOLD_CYCLES = 400;
   // worst case per beat: a scroll copy plus the longest gaps on both
   // sides, for ~1400 beats, plus the blanking pass, taken 4x over
   localparam int CYCLE_LIMIT = 12_000_000;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = '0;
   logic       hold_off  = 1'b0;

   int fail_count;
   int pending;
   int req_beats  = 0;
   int items_sent = 0;
   int cycles     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_mode_terminal_writer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   text_mode_terminal_writer_unit_checker i_console_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(4, 1);
      end
      return $urandom_range(60, 12);
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic [7:0] ch,
                                        row_type row, col_type col);
      req_type r;
      r.cmd       = cmd;
      r.char_code = ch;
      r.read_row  = row;
      r.read_col  = col;
      return r;
   endfunction

   function automatic row_type any_row();
      return row_type'($urandom_range(31));
   endfunction

   function automatic col_type any_col();
      return col_type'($urandom_range(127));
   endfunction

   // offer one req beat after a random gap and wait until it is taken
   task automatic send_req(input req_type beat);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      req_beats++;
      if (beat.cmd != CMD_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic send_put(input logic [7:0] ch);
      send_req(make_req(CMD_PUT, ch, any_row(), any_col()));
   endtask

   task automatic send_read(input row_type row, input col_type col);
      send_req(make_req(CMD_READ, 8'($urandom_range(255)), row, col));
   endtask

   task automatic read_on_screen();
      send_read(row_type'($urandom_range(ROWS - 1)), col_type'($urandom_range(COLUMNS - 1)));
   endtask

   // drop valid and let every owed response come back
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_color(input logic [7:0] color);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= color;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // typing: random bytes with newlines, backspaces and the odd read
   task automatic send_text_run();
      int n;
      int r;
      n = $urandom_range(40, 5);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 8) begin
            send_put(CH_NEWLINE);
         end else if (r < 13) begin
            send_put(CH_BACKSPACE);
         end else if (r < 17) begin
            read_on_screen();
         end else begin
            send_put(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic send_read_run();
      int n;
      n = $urandom_range(15, 3);
      repeat (n) begin
         if ($urandom_range(99) < 85) begin
            read_on_screen();
         end else begin
            send_read(any_row(), any_col());
         end
      end
   endtask

   // fully random beats, unused command and clear included
   task automatic send_noise();
      int n;
      n = $urandom_range(4, 1);
      repeat (n) begin
         send_req(make_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                           any_row(), any_col()));
      end
   endtask

   task automatic send_directed();
      send_read(row_type'(0), col_type'(0));
      send_read(row_type'(ROWS), col_type'(0));
      send_read(row_type'(0), col_type'(COLUMNS));
      send_read(row_type'(31), col_type'(127));
      send_req(make_req(CMD_UNUSED, 8'hFF, row_type'(31), col_type'(127)));
      // backspace at home
      send_put(CH_BACKSPACE);
      send_put(8'h00);
      send_put(8'hFF);
      send_put(8'h41);
      send_put(CH_NEWLINE);
      // backspace at line start, then a put in the last column wraps
      send_put(CH_BACKSPACE);
      send_put(8'h7E);
      send_read(row_type'(0), col_type'(COLUMNS - 1));
      send_read(row_type'(0), col_type'(1));
      send_read(row_type'(ROWS - 1), col_type'(COLUMNS - 1));
      send_req(make_req(CMD_CLEAR, 8'h00, row_type'(0), col_type'(0)));
      send_read(row_type'(0), col_type'(0));
   endtask

   // rsp side idling, with long stretches of no stall
   initial begin : rsp_stall_gen
      int run;
      int gap;
      forever begin
         run = ($urandom_range(19) == 0) ? 300 : $urandom_range(12, 1);
         gap = pick_gap();
         repeat (run) @(negedge clock) rsp_stall <= hold_off;
         repeat (gap) @(negedge clock) rsp_stall <= 1'b1;
      end
   end

   // one long hold-off on rsp so the block backs up into req
   initial begin : rsp_holdoff
      wait (req_beats >= 200);
      @(posedge clock) hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int sel;
      logic [7:0] color;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      write_color(8'h00);
      send_directed();
      wait_idle();

      // random phases, each under its own text color
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            color = 8'hFF;
         end else if (phase == 2) begin
            color = 8'h00;
         end else begin
            color = 8'($urandom_range(255));
         end
         write_color(color);
         while (items_sent < ITEMS * (phase + 1) / PHASES) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
               send_text_run();
            end else if (sel < 85) begin
               send_read_run();
            end else begin
               send_noise();
            end
         end
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
